// ===== src/lpfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and constants of the length prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  // classified operation codes passed from front to back
  localparam logic [2:0] OP_NOP     = 3'd0;
  localparam logic [2:0] OP_BEGIN   = 3'd1;
  localparam logic [2:0] OP_DATA    = 3'd2;
  localparam logic [2:0] OP_CONNECT = 3'd3;
  localparam logic [2:0] OP_FAIL    = 3'd4;

  // raw input codes
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;
  localparam logic [1:0] EV_CONNECT = 2'd0;
  localparam logic [1:0] EV_FAIL    = 2'd1;

  // result status codes
  localparam logic [1:0] RES_RUNNING   = 2'd0;
  localparam logic [1:0] RES_SUCCESS   = 2'd1;
  localparam logic [1:0] RES_CONN_FAIL = 2'd2;
  localparam logic [1:0] RES_LINK_ERR  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_LENGTH   = 2'd0;
  localparam logic [1:0] REG_BUFFER_LIMIT = 2'd1;

  localparam logic [15:0] MAX_LENGTH_RST   = 16'd4096;
  localparam logic [15:0] BUFFER_LIMIT_RST = 16'd4096;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       nt;
  } op_t;

endpackage
`default_nettype wire

// ===== src/lpfr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpfr_front
// Accepts input words, classifies them into operations and registers them.
// ----------------------------------------------------------------------------
module lpfr_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   command,
  input  wire logic [7:0]   data_byte,
  input  wire logic [1:0]   event_kind,
  input  wire logic         conn_test,
  output logic              op_valid,
  input  wire logic         op_ready,
  output lpfr_pkg::op_t     op
);

  logic          valid_r, valid_nxt;
  lpfr_pkg::op_t op_r;
  lpfr_pkg::op_t op_nxt;

  assign in_ready = !valid_r || op_ready;
  assign op_valid = valid_r;
  assign op       = op_r;

  always_comb begin
    op_nxt.data = data_byte;
    op_nxt.nt   = conn_test;
    unique case (command)
      lpfr_pkg::CMD_BEGIN: op_nxt.kind = lpfr_pkg::OP_BEGIN;
      lpfr_pkg::CMD_DATA:  op_nxt.kind = lpfr_pkg::OP_DATA;
      lpfr_pkg::CMD_EVENT: begin
        unique case (event_kind)
          lpfr_pkg::EV_CONNECT: op_nxt.kind = lpfr_pkg::OP_CONNECT;
          lpfr_pkg::EV_FAIL:    op_nxt.kind = lpfr_pkg::OP_FAIL;
          default:              op_nxt.kind = lpfr_pkg::OP_NOP;
        endcase
      end
      default: op_nxt.kind = lpfr_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r <= op_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/lpfr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpfr_queue
// Short fifo of classified operations between front and back.
// ----------------------------------------------------------------------------
module lpfr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire lpfr_pkg::op_t wr_op,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output lpfr_pkg::op_t      rd_op
);

  lpfr_pkg::op_t                 mem_r [lpfr_pkg::Q_DEPTH];
  logic [lpfr_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [lpfr_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [lpfr_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          push, pop;

  localparam logic [lpfr_pkg::QPTR_W-1:0] PTR_LAST = lpfr_pkg::QPTR_W'(lpfr_pkg::Q_DEPTH - 1);
  localparam logic [lpfr_pkg::QCNT_W-1:0] CNT_FULL = lpfr_pkg::QCNT_W'(lpfr_pkg::Q_DEPTH);

  assign wr_ready = (count_r != CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_op    = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule
`default_nettype wire

// ===== src/lpfr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpfr_back
// Protocol state machine, config registers and registered result word.
// ----------------------------------------------------------------------------
module lpfr_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          op_valid,
  output logic               op_ready,
  input  wire lpfr_pkg::op_t op,
  output logic               res_valid,
  input  wire logic          res_ready,
  output logic [1:0]         status,
  output logic               send_request,
  output logic               payload_valid,
  output logic [7:0]         payload_byte,
  output logic               payload_last
);

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_WAIT_HIGH = 3'd2;
  localparam logic [2:0] ST_WAIT_LOW  = 3'd3;
  localparam logic [2:0] ST_PAYLOAD   = 3'd4;

  logic [15:0] max_length_r, buffer_limit_r;
  logic [2:0]  state_r, state_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        test_r, test_nxt;
  logic [15:0] cnt_inc, len_low;

  logic        vld_r;
  logic [1:0]  status_r, status_nxt;
  logic        send_r, send_nxt;
  logic        pv_r, pv_nxt;
  logic [7:0]  pb_r, pb_nxt;
  logic        pl_r, pl_nxt;
  logic        pop;

  assign op_ready      = !vld_r || res_ready;
  assign pop           = op_valid && op_ready;
  assign res_valid     = vld_r;
  assign status        = status_r;
  assign send_request  = send_r;
  assign payload_valid = pv_r;
  assign payload_byte  = pb_r;
  assign payload_last  = pl_r;

  assign cnt_inc = cnt_r + 16'd1;
  assign len_low = {len_r[15:8], op.data};

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    test_nxt   = test_r;
    status_nxt = lpfr_pkg::RES_RUNNING;
    send_nxt   = 1'b0;
    pv_nxt     = 1'b0;
    pb_nxt     = 8'd0;
    pl_nxt     = 1'b0;
    unique case (op.kind)
      lpfr_pkg::OP_BEGIN: begin
        state_nxt = ST_IDLE;
        test_nxt  = op.nt;
        len_nxt   = 16'd0;
        cnt_nxt   = 16'd0;
      end
      lpfr_pkg::OP_DATA: begin
        unique case (state_r)
          ST_WAIT_HIGH: begin
            len_nxt   = {op.data, 8'd0};
            state_nxt = ST_WAIT_LOW;
          end
          ST_WAIT_LOW: begin
            len_nxt = len_low;
            if (len_low >= max_length_r) begin
              state_nxt  = ST_DONE;
              status_nxt = lpfr_pkg::RES_LINK_ERR;
            end else begin
              state_nxt = ST_PAYLOAD;
            end
          end
          ST_PAYLOAD: begin
            if (cnt_r >= buffer_limit_r) begin
              // overflow byte is dropped
              state_nxt  = ST_DONE;
              status_nxt = lpfr_pkg::RES_LINK_ERR;
            end else begin
              cnt_nxt = cnt_inc;
              pv_nxt  = 1'b1;
              pb_nxt  = op.data;
              if (cnt_inc == len_r) begin
                pl_nxt     = 1'b1;
                state_nxt  = ST_DONE;
                status_nxt = lpfr_pkg::RES_SUCCESS;
              end
            end
          end
          default: ;
        endcase
      end
      lpfr_pkg::OP_CONNECT: begin
        if (state_r == ST_IDLE) begin
          if (test_r) begin
            state_nxt  = ST_DONE;
            status_nxt = lpfr_pkg::RES_SUCCESS;
          end else begin
            state_nxt = ST_WAIT_HIGH;
            send_nxt  = 1'b1;
          end
        end
      end
      lpfr_pkg::OP_FAIL: begin
        if (state_r == ST_IDLE) begin
          state_nxt  = ST_DONE;
          status_nxt = lpfr_pkg::RES_CONN_FAIL;
        end else if (state_r != ST_DONE) begin
          cnt_nxt    = 16'd0;
          state_nxt  = ST_DONE;
          status_nxt = lpfr_pkg::RES_LINK_ERR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_DONE;
      len_r          <= 16'd0;
      cnt_r          <= 16'd0;
      test_r         <= 1'b0;
      vld_r          <= 1'b0;
      max_length_r   <= lpfr_pkg::MAX_LENGTH_RST;
      buffer_limit_r <= lpfr_pkg::BUFFER_LIMIT_RST;
    end else begin
      if (cfg_we && cfg_index == lpfr_pkg::REG_MAX_LENGTH) begin
        max_length_r <= cfg_data;
      end
      if (cfg_we && cfg_index == lpfr_pkg::REG_BUFFER_LIMIT) begin
        buffer_limit_r <= cfg_data;
      end
      if (pop) begin
        state_r <= state_nxt;
        len_r   <= len_nxt;
        cnt_r   <= cnt_nxt;
        test_r  <= test_nxt;
      end
      if (op_ready) begin
        vld_r <= op_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= status_nxt;
      send_r   <= send_nxt;
      pv_r     <= pv_nxt;
      pb_r     <= pb_nxt;
      pl_r     <= pl_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/length_prefixed_frame_receiver_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_top
// Receiver for a connect-then-exchange link with two-byte length framing.
// ----------------------------------------------------------------------------
// path: an accepted input word passes the front register, a queue slot and
//   the result register in the back before its result word appears
// throughput: one word per cycle while out_tready is held high; every word yields exactly one result word
// reset: rst_n synchronous, active low; state returns to done, length and
//   count clear, max_length and buffer_limit return to 4096, queue empties
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input word channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // data_byte[7:0], event_kind[9:8], conn_test[10]
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  // result word channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // status[1:0], send_request[2], payload_byte[10:3]
  output logic             out_tuser,  // payload_valid[0]
  output logic             out_tlast,  // payload_last
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // front to queue
  logic          f_valid, f_ready;
  lpfr_pkg::op_t f_op;
  // queue to back
  logic          q_valid, q_ready;
  lpfr_pkg::op_t q_op;

  logic [1:0] res_status;
  logic       res_send;
  logic [7:0] res_byte;

  // config registers are always writable; the sender must write them only
  // while no word is in flight, which the block itself does not enforce
  assign cfg_ready = 1'b1;

  // front: decode command and event kind into one operation code
  lpfr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .command      (in_tuser),
    .data_byte    (in_tdata[7:0]),
    .event_kind   (in_tdata[9:8]),
    .conn_test    (in_tdata[10]),
    .op_valid     (f_valid),
    .op_ready     (f_ready),
    .op           (f_op)
  );

  // short queue lets front and back stall independently
  lpfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_op    (f_op),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_op    (q_op)
  );

  // back: protocol state machine and registered result word
  lpfr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op_valid      (q_valid),
    .op_ready      (q_ready),
    .op            (q_op),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .status        (res_status),
    .send_request  (res_send),
    .payload_valid (out_tuser),
    .payload_byte  (res_byte),
    .payload_last  (out_tlast)
  );

  // pack result fields, zero fill to whole bytes
  assign out_tdata = {5'd0, res_byte, res_send, res_status};

endmodule
`default_nettype wire
